>>> sv/tlq_pkg.sv
`timescale 1ns / 1ps
package tlq_pkg;
    localparam int MaxNodesDef   = 1024;
    localparam int LiftLevelsDef = 10;
    localparam int NodeW  = 10;
    localparam int DepthW = 10;
    localparam int CountW = 11;
    localparam int DistW  = 11;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [NodeW-1:0]  node_index;
        logic [NodeW-1:0]  other_node;
        logic [DepthW-1:0] node_depth;
    } t_in_item;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic [NodeW-1:0] common_ancestor;
    } t_out_item;
endpackage

>>> sv/tlq_ram.sv
`timescale 1ns / 1ps
module tlq_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/tree_lca_distance_query_unit.sv
`timescale 1ns / 1ps
// Load: an accepted load item writes the parent and depth memories in S_LOAD, then the block is ready again.
// Build: level 0 copies the parent of each of the N nodes, two dependent jump table reads per higher entry.
// Query: reads both depths, orders the pair, lifts the deeper node over the set bits of the depth
// difference and, unless the lifted node already matches, lifts both from the top level down and
// takes the parent; one item is in work at a time, so no new item is taken until the result is loaded.
// Reset (synchronous, active low) clears control state and sets r_count to 1; memories are kept.
module tree_lca_distance_query_unit #(
    parameter int MAX_NODES   = tlq_pkg::MaxNodesDef,
    parameter int LIFT_LEVELS = tlq_pkg::LiftLevelsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tlq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tlq_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [tlq_pkg::CountW-1:0] i_cfg_wdata
);
    import tlq_pkg::*;

    localparam int AW  = $clog2(MAX_NODES);
    localparam int LW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int JD  = MAX_NODES * LIFT_LEVELS;
    localparam int JAW = $clog2(JD);
    localparam int NCW = AW + 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LOAD  = 5'd1;
    localparam logic [4:0] S_B0R   = 5'd2;  // read parent of node i
    localparam logic [4:0] S_B0W   = 5'd3;  // write level 0
    localparam logic [4:0] S_BR1   = 5'd4;  // read jump(i, j-1)
    localparam logic [4:0] S_BR2   = 5'd5;  // read jump(that, j-1)
    localparam logic [4:0] S_BW    = 5'd6;
    localparam logic [4:0] S_QD    = 5'd7;  // depth read of a
    localparam logic [4:0] S_QD2   = 5'd8;  // depth read of b
    localparam logic [4:0] S_QS    = 5'd9;  // order the pair
    localparam logic [4:0] S_QL    = 5'd10; // lift u over diff bits
    localparam logic [4:0] S_QC    = 5'd11; // compare after the lift
    localparam logic [4:0] S_QA    = 5'd12; // both-lift: read u
    localparam logic [4:0] S_QB    = 5'd13; // both-lift: read v
    localparam logic [4:0] S_QE    = 5'd14; // both-lift: compare
    localparam logic [4:0] S_QP    = 5'd15; // read parent of u
    localparam logic [4:0] S_QDL   = 5'd16; // read depth of lca
    localparam logic [4:0] S_QF    = 5'd17;

    logic [4:0]        r_state;
    logic [CountW-1:0] r_count;
    t_in_item          r_item;
    logic [AW-1:0]     r_i, r_u, r_v, r_t;
    logic [LW-1:0]     r_j;
    logic              r_wait;
    logic [DepthW-1:0] r_du, r_dv, r_diff;
    logic              r_ovalid;
    t_out_item         r_oitem;

    // memory ports
    logic              p_we, d_we, j_we;
    logic [AW-1:0]     p_ra, d_ra, wa;
    logic [JAW-1:0]    j_ra, j_wa;
    logic [AW-1:0]     j_wd;
    logic [NodeW-1:0]  p_rd;
    logic [DepthW-1:0] d_rd;
    logic [AW-1:0]     j_rd;

    logic              res_load;
    logic [DistW-1:0]  sum_d, twice_lca;

    logic [NCW-1:0] build_n;
    assign build_n = (r_count > CountW'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(r_count);

    function automatic logic [JAW-1:0] jaddr(input logic [AW-1:0] n, input logic [LW-1:0] l);
        return JAW'(n) * JAW'(LIFT_LEVELS) + JAW'(l);
    endfunction

    tlq_ram #(.WIDTH(NodeW), .DEPTH(MAX_NODES)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(wa),
        .i_wdata(r_item.other_node), .i_raddr(p_ra), .o_rdata(p_rd));
    tlq_ram #(.WIDTH(DepthW), .DEPTH(MAX_NODES)) u_depth (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(wa),
        .i_wdata(r_item.node_depth), .i_raddr(d_ra), .o_rdata(d_rd));
    tlq_ram #(.WIDTH(AW), .DEPTH(JD)) u_jump (
        .i_clk(i_clk), .i_we(j_we), .i_waddr(j_wa),
        .i_wdata(j_wd), .i_raddr(j_ra), .o_rdata(j_rd));

    logic [AW-1:0] pwrap;
    assign pwrap = AW'(p_rd);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    assign wa   = AW'(r_item.node_index);
    assign p_we = (r_state == S_LOAD);
    assign d_we = (r_state == S_LOAD);
    assign j_we = (r_state == S_B0W) || (r_state == S_BW);
    assign j_wa = jaddr(r_i, r_j);
    assign j_wd = (r_state == S_B0W) ? pwrap : j_rd;

    always_comb begin
        unique case (r_state)
            S_QP:    p_ra = r_u;
            default: p_ra = r_i;
        endcase
        unique case (r_state)
            S_QD:    d_ra = AW'(r_item.node_index);
            S_QD2:   d_ra = AW'(r_item.other_node);
            S_QDL:   d_ra = pwrap;
            default: d_ra = r_u;
        endcase
        unique case (r_state)
            S_BR1:      j_ra = jaddr(r_i, r_j - LW'(1));
            S_BR2:      j_ra = jaddr(j_rd, r_j - LW'(1));
            S_QL, S_QA: j_ra = jaddr(r_u, r_j);
            S_QB:       j_ra = jaddr(r_v, r_j);
            default:    j_ra = jaddr(r_i, r_j);
        endcase
    end

    // In the lift pass r_wait marks the cycle in which the jump table datum is back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CountW'(1);
            r_wait  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_wait <= 1'b0;
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in_item;
                        r_i    <= '0;
                        r_j    <= '0;
                        unique case (i_in_item.cmd)
                            CMD_LOAD:  r_state <= S_LOAD;
                            CMD_BUILD: r_state <= (build_n == '0) ? S_IDLE : S_B0R;
                            CMD_QUERY: r_state <= S_QD;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_B0R: r_state <= S_B0W;
                S_B0W: begin
                    if (NCW'(r_i) == build_n - NCW'(1)) begin
                        r_i <= '0;
                        r_j <= LW'(1);
                        r_state <= (LIFT_LEVELS > 1) ? S_BR1 : S_IDLE;
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_state <= S_B0R;
                    end
                end
                S_BR1: r_state <= S_BR2;
                S_BR2: r_state <= S_BW;
                S_BW: begin
                    if (NCW'(r_i) == build_n - NCW'(1)) begin
                        r_i <= '0;
                        if (32'(r_j) == LIFT_LEVELS - 1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + LW'(1);
                            r_state <= S_BR1;
                        end
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_state <= S_BR1;
                    end
                end
                S_QD: r_state <= S_QD2;
                S_QD2: begin
                    r_du <= d_rd;
                    r_state <= S_QS;
                end
                S_QS: begin
                    // Order the pair so that u is the deeper node.
                    r_dv <= d_rd;
                    if (r_du < d_rd) begin
                        r_u <= AW'(r_item.other_node);
                        r_v <= AW'(r_item.node_index);
                        r_diff <= d_rd - r_du;
                    end else begin
                        r_u <= AW'(r_item.node_index);
                        r_v <= AW'(r_item.other_node);
                        r_diff <= r_du - d_rd;
                    end
                    r_state <= S_QL;
                end
                S_QL: begin
                    if (!r_wait && r_diff[0]) begin
                        r_wait <= 1'b1;
                    end else begin
                        if (r_wait) begin
                            r_u <= j_rd;
                        end
                        r_wait <= 1'b0;
                        r_diff <= r_diff >> 1;
                        if (32'(r_j) == LIFT_LEVELS - 1) begin
                            r_state <= S_QC;
                        end else begin
                            r_j <= r_j + LW'(1);
                        end
                    end
                end
                S_QC: begin
                    r_j <= LW'(LIFT_LEVELS - 1);
                    r_state <= (r_u == r_v) ? S_QF : S_QA;
                end
                S_QA: r_state <= S_QB;
                S_QB: begin
                    r_t <= j_rd;
                    r_state <= S_QE;
                end
                S_QE: begin
                    // j_rd holds jump(v, j) and r_t holds jump(u, j).
                    if (r_t != j_rd) begin
                        r_u <= r_t;
                        r_v <= j_rd;
                    end
                    if (r_j == '0) begin
                        r_state <= S_QP;
                    end else begin
                        r_j <= r_j - LW'(1);
                        r_state <= S_QA;
                    end
                end
                S_QP: r_state <= S_QDL;
                S_QDL: begin
                    r_u <= pwrap;
                    r_state <= S_QF;
                end
                S_QF: begin
                    if (res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The query holds in its last state until the output register is free.
    assign res_load  = (r_state == S_QF) && (!r_ovalid || i_out_ready);
    assign sum_d     = DistW'(r_du) + DistW'(r_dv);
    assign twice_lca = DistW'({d_rd, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_oitem.common_ancestor <= NodeW'(r_u);
            r_oitem.distance <= (sum_d < twice_lca) ? '0 : sum_d - twice_lca;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("ready while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        j_we |-> (r_state == S_B0W || r_state == S_BW))
        else $error("jump table written outside build");
endmodule

>>> tb/tlq_checker.sv
`timescale 1ns / 1ps
module tlq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tlq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tlq_pkg::t_out_item i_out_item,
    input  logic               i_cfg_we,
    input  logic [tlq_pkg::CountW-1:0] i_cfg_wdata,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tlq_pkg::*;

    localparam int Nodes  = MaxNodesDef;
    localparam int Levels = LiftLevelsDef;

    logic [CountW-1:0] build_count = CountW'(1);
    logic [NodeW-1:0]  parent_of [0:Nodes-1];
    logic [DepthW-1:0] depth_of  [0:Nodes-1];
    logic [NodeW-1:0]  ancestor  [0:Nodes*Levels-1];
    t_out_item         pending_answers [$];

    function automatic logic [NodeW-1:0] hop(logic [NodeW-1:0] node, int level);
        return ancestor[int'(node) * Levels + level];
    endfunction

    task automatic fill_ancestors();
        int n;
        n = (build_count > Nodes) ? Nodes : int'(build_count);
        for (int i = 0; i < n; i++) ancestor[i*Levels] = parent_of[i];
        for (int j = 1; j < Levels; j++)
            for (int i = 0; i < n; i++)
                ancestor[i*Levels + j] = hop(hop(i[NodeW-1:0], j-1), j-1);
    endtask

    function automatic t_out_item lift_query(logic [NodeW-1:0] a, logic [NodeW-1:0] b);
        logic [NodeW-1:0] u, v, pu, pv, lca;
        int du, dv, diff, path_len;
        t_out_item r;
        du = depth_of[a];
        dv = depth_of[b];
        if (du < dv) begin
            u = b; v = a; diff = dv - du;
        end else begin
            u = a; v = b; diff = du - dv;
        end
        for (int i = 0; i < Levels; i++)
            if (diff[i]) u = hop(u, i);
        if (u == v) begin
            lca = u;
        end else begin
            for (int i = Levels - 1; i >= 0; i--) begin
                pu = hop(u, i);
                pv = hop(v, i);
                if (pu != pv) begin
                    u = pu; v = pv;
                end
            end
            lca = parent_of[u];
        end
        path_len = du + dv - 2 * int'(depth_of[lca]);
        if (path_len < 0) path_len = 0;
        r.distance        = path_len[DistW-1:0];
        r.common_ancestor = lca;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            build_count = CountW'(1);
            pending_answers.delete();
            for (int i = 0; i < Nodes; i++) begin
                parent_of[i] = '0;
                depth_of[i]  = '0;
            end
            for (int i = 0; i < Nodes*Levels; i++) ancestor[i] = '0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: dist %0d lca %0d",
                                 i_out_item.distance, i_out_item.common_ancestor);
                end else begin
                    want = pending_answers.pop_front();
                    if (want !== i_out_item) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected dist %0d lca %0d, got dist %0d lca %0d",
                                     want.distance, want.common_ancestor,
                                     i_out_item.distance, i_out_item.common_ancestor);
                    end
                end
            end
            if (i_cfg_we) build_count = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                case (i_in_item.cmd)
                    CMD_LOAD: begin
                        parent_of[i_in_item.node_index] = i_in_item.other_node;
                        depth_of[i_in_item.node_index]  = i_in_item.node_depth;
                    end
                    CMD_BUILD: fill_ancestors();
                    CMD_QUERY: pending_answers = {pending_answers,
                        lift_query(i_in_item.node_index, i_in_item.other_node)};
                    default: ;
                endcase
            end
        end
        o_pending = pending_answers.size();
    end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import tlq_pkg::*;

    localparam logic [1:0] CmdUnused = 2'd3;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 0;
    t_out_item out_item;
    logic cfg_we = 0;
    logic [CountW-1:0] cfg_wdata = '0;
    int fail_count, pending;

    logic in_taken = 0;
    int results_taken = 0;
    int items_sent = 0;
    int last_build_n = 1;
    bit steady = 0;
    logic [NodeW-1:0]  tree_parent [0:MaxNodesDef-1];
    logic [DepthW-1:0] tree_depth  [0:MaxNodesDef-1];

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    tree_lca_distance_query_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata)
    );

    tlq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        in_taken <= in_valid && in_ready;
        if (out_valid && out_ready) results_taken <= results_taken + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1;
        in_item  = it;
        do @(negedge i_clk); while (!in_taken);
        if (it.cmd != CmdUnused) items_sent++;
    endtask

    task automatic send_cmd(logic [1:0] c, int a, int b, int d);
        t_in_item it;
        it.cmd = c;
        it.node_index = a[NodeW-1:0];
        it.other_node = b[NodeW-1:0];
        it.node_depth = d[DepthW-1:0];
        send(it);
    endtask

    // The register may change only once nothing is in flight, including a build.
    task automatic set_count(int v);
        in_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (3 * last_build_n * LiftLevelsDef + 60) @(negedge i_clk);
        cfg_we = 1;
        cfg_wdata = v[CountW-1:0];
        @(negedge i_clk);
        cfg_we = 0;
        last_build_n = (v > MaxNodesDef) ? MaxNodesDef : v;
    endtask

    task automatic load_tree(int n, int chain_len);
        tree_parent[0] = '0;
        tree_depth[0]  = '0;
        for (int i = 1; i < n; i++) begin
            tree_parent[i] = NodeW'((i < chain_len) ? i - 1 : $urandom_range(0, i - 1));
            tree_depth[i]  = tree_depth[tree_parent[i]] + DepthW'(1);
        end
        for (int i = 0; i < n; i++)
            send_cmd(CMD_LOAD, i, tree_parent[i], tree_depth[i]);
        send_cmd(CMD_BUILD, $urandom, $urandom, $urandom);
    endtask

    task automatic random_queries(int n, int count);
        int a, b;
        for (int k = 0; k < count; k++) begin
            a = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
                0: b = a;
                1: b = tree_parent[a];
                default: b = $urandom_range(0, n - 1);
            endcase
            if ($urandom_range(0, 15) == 0)
                send_cmd(CmdUnused, $urandom, $urandom, $urandom);
            send_cmd(CMD_QUERY, a, b, $urandom);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off that backs the block up.
    initial begin
        bit held;
        int stall;
        held = 0;
        @(posedge i_rst_n);
        forever begin
            if (!held && results_taken >= 30) begin
                out_ready = 0;
                repeat (400) @(negedge i_clk);
                held = 1;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    out_ready = 0;
                    repeat (stall) @(negedge i_clk);
                end
                out_ready = 1;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        int n, k, q;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;

        // Single node under the reset count, plus an unused command.
        send_cmd(CMD_LOAD, 0, 0, 0);
        send_cmd(CMD_BUILD, 0, 0, 0);
        send_cmd(CMD_QUERY, 0, 0, 0);
        send_cmd(CmdUnused, 1023, 1023, 1023);

        // Full-size tree with a long chain; the count saturates at the node limit.
        set_count(2047);
        load_tree(MaxNodesDef, 700);
        send_cmd(CMD_QUERY, 1023, 0, 1023);
        send_cmd(CMD_QUERY, 0, 1023, 0);
        send_cmd(CMD_QUERY, 1023, 1023, 0);
        send_cmd(CMD_QUERY, 699, 0, 0);
        send_cmd(CMD_QUERY, 0, 699, 0);
        random_queries(MaxNodesDef, 60);

        // A zero count builds nothing, so the old table stays valid.
        set_count(0);
        send_cmd(CMD_BUILD, 0, 0, 0);
        random_queries(MaxNodesDef, 5);

        while (items_sent < 1650) begin
            steady = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                             : $urandom_range(1, 64);
            set_count(n);
            load_tree(n, $urandom_range(0, n));
            q = $urandom_range(20, 40);
            random_queries(n, q);
            // Occasionally give a node a depth that disagrees with its parent.
            if (n > 1 && $urandom_range(0, 2) == 0) begin
                k = $urandom_range(1, n - 1);
                send_cmd(CMD_LOAD, k, tree_parent[k], $urandom_range(0, 1023));
                random_queries(n, 10);
            end
        end
        steady = 0;

        in_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (3 * last_build_n * LiftLevelsDef + 100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
